// File: rtl/odometry_path_record_replay_defines.svh
`ifndef ODOMETRY_PATH_RECORD_REPLAY_DEFINES_SVH
`define ODOMETRY_PATH_RECORD_REPLAY_DEFINES_SVH

// Implication checked in the same cycle.
`define OPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("opr assertion failed");

// Implication checked in the next cycle.
`define OPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("opr assertion failed");

`endif

// File: rtl/opr_pkg.sv
`default_nettype none

package opr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int IW = 4;
  localparam int XW = 52;
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] TRIG_GAIN = 34'sd652032874;

  localparam logic [1:0] FUNC_RECORD  = 2'd0;
  localparam logic [1:0] FUNC_REPLAY  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  localparam logic [2:0] REG_HEADING_ZERO   = 3'd0;
  localparam logic [2:0] REG_RECORD_SPACING = 3'd1;
  localparam logic [2:0] REG_ARRIVE_RADIUS  = 3'd2;
  localparam logic [2:0] REG_REPLAY_REVERSE = 3'd3;
  localparam logic [2:0] REG_POINT_LIMIT    = 3'd4;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_ROT_INIT = 5'd2;
  localparam logic [4:0] OP_ROT_STEP = 5'd3;
  localparam logic [4:0] OP_MUL_X    = 5'd4;
  localparam logic [4:0] OP_ACC_X    = 5'd5;
  localparam logic [4:0] OP_ACC_Y    = 5'd6;
  localparam logic [4:0] OP_RECORD   = 5'd7;
  localparam logic [4:0] OP_RD       = 5'd8;
  localparam logic [4:0] OP_DIFF     = 5'd9;
  localparam logic [4:0] OP_SQ_X     = 5'd10;
  localparam logic [4:0] OP_SQ_Y     = 5'd11;
  localparam logic [4:0] OP_SQ_R     = 5'd12;
  localparam logic [4:0] OP_ARRIVE   = 5'd13;
  localparam logic [4:0] OP_VEC_INIT = 5'd14;
  localparam logic [4:0] OP_VEC_STEP = 5'd15;
  localparam logic [4:0] OP_BEAR     = 5'd16;
  localparam logic [4:0] OP_RESTART  = 5'd17;
  localparam logic [4:0] OP_CLEAR    = 5'd18;
  localparam logic [4:0] OP_OUT      = 5'd19;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] step_dist;
    logic [15:0]        heading;
  } item_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] target_heading;
    logic signed [15:0] relative_heading;
    logic               replay_active;
    logic               point_switched;
    logic signed [11:0] target_index;
    logic [10:0]        stored_points;
  } item_out_t;

  typedef struct packed {
    logic [4:0]    op;
    logic [IW-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       in_range;
    logic       arrive_sw;
    logic       zero_vec;
  } dp_stat_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_turn(input logic [IW-1:0] i);
    logic [31:0] a;
    case (i)
      4'd0:    a = 32'd536870912;
      4'd1:    a = 32'd316933406;
      4'd2:    a = 32'd167458907;
      4'd3:    a = 32'd85004756;
      4'd4:    a = 32'd42667331;
      4'd5:    a = 32'd21354465;
      4'd6:    a = 32'd10680862;
      4'd7:    a = 32'd5340245;
      4'd8:    a = 32'd2670163;
      4'd9:    a = 32'd1335087;
      4'd10:   a = 32'd667544;
      4'd11:   a = 32'd333772;
      4'd12:   a = 32'd166886;
      4'd13:   a = 32'd83443;
      4'd14:   a = 32'd41722;
      default: a = 32'd20861;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/opr_ctrl.sv
`default_nettype none

module opr_ctrl import opr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_ROT_INIT = 5'd2;
  localparam logic [4:0] S_ROT      = 5'd3;
  localparam logic [4:0] S_MUL_X    = 5'd4;
  localparam logic [4:0] S_ACC_X    = 5'd5;
  localparam logic [4:0] S_ACC_Y    = 5'd6;
  localparam logic [4:0] S_RECORD   = 5'd7;
  localparam logic [4:0] S_RD       = 5'd8;
  localparam logic [4:0] S_DIFF     = 5'd9;
  localparam logic [4:0] S_SQ_X     = 5'd10;
  localparam logic [4:0] S_SQ_Y     = 5'd11;
  localparam logic [4:0] S_SQ_R     = 5'd12;
  localparam logic [4:0] S_ARR      = 5'd13;
  localparam logic [4:0] S_RD2      = 5'd14;
  localparam logic [4:0] S_DIFF2    = 5'd15;
  localparam logic [4:0] S_VINIT    = 5'd16;
  localparam logic [4:0] S_VEC      = 5'd17;
  localparam logic [4:0] S_BEAR     = 5'd18;
  localparam logic [4:0] S_RESTART  = 5'd19;
  localparam logic [4:0] S_CLEAR    = 5'd20;
  localparam logic [4:0] S_DONE     = 5'd21;

  localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);

  logic [4:0]    state_r, state_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.iter      = iter_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.func)
          FUNC_RECORD, FUNC_REPLAY: state_nxt = S_ROT_INIT;
          FUNC_RESTART:             state_nxt = S_RESTART;
          default:                  state_nxt = S_CLEAR;
        endcase
      end
      S_ROT_INIT: begin
        cmd.op    = OP_ROT_INIT;
        iter_nxt  = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op   = OP_ROT_STEP;
        iter_nxt = iter_r + IW'(1);
        if (iter_r == LAST_ITER) state_nxt = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.op    = OP_MUL_X;
        state_nxt = S_ACC_X;
      end
      S_ACC_X: begin
        cmd.op    = OP_ACC_X;
        state_nxt = S_ACC_Y;
      end
      S_ACC_Y: begin
        cmd.op    = OP_ACC_Y;
        state_nxt = (stat.func == FUNC_RECORD) ? S_RECORD : S_RD;
      end
      S_RECORD: begin
        cmd.op    = OP_RECORD;
        state_nxt = S_DONE;
      end
      S_RD: begin
        if (stat.in_range) begin
          cmd.op    = OP_RD;
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_SQ_X;
      end
      S_SQ_X: begin
        cmd.op    = OP_SQ_X;
        state_nxt = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.op    = OP_SQ_Y;
        state_nxt = S_SQ_R;
      end
      S_SQ_R: begin
        cmd.op    = OP_SQ_R;
        state_nxt = S_ARR;
      end
      S_ARR: begin
        cmd.op    = OP_ARRIVE;
        state_nxt = stat.arrive_sw ? S_RD2 : S_VINIT;
      end
      S_RD2: begin
        // target moved on; re-fetch only if the new one exists
        if (stat.in_range) begin
          cmd.op    = OP_RD;
          state_nxt = S_DIFF2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIFF2: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_VINIT;
      end
      S_VINIT: begin
        cmd.op    = OP_VEC_INIT;
        iter_nxt  = '0;
        state_nxt = stat.zero_vec ? S_DONE : S_VEC;
      end
      S_VEC: begin
        cmd.op   = OP_VEC_STEP;
        iter_nxt = iter_r + IW'(1);
        if (iter_r == LAST_ITER) state_nxt = S_BEAR;
      end
      S_BEAR: begin
        cmd.op    = OP_BEAR;
        state_nxt = S_DONE;
      end
      S_RESTART: begin
        cmd.op    = OP_RESTART;
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/opr_dp.sv
`default_nettype none

module opr_dp import opr_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire item_in_t    in_data,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  output item_out_t        out_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = CW + 1;
  localparam int LW = (CW > 11) ? CW : 11;

  // configuration
  logic [15:0] hz_r, spacing_r, radius_r;
  logic        reverse_r;
  logic [10:0] limit_r;

  // tracking state
  logic [1:0]         func_r;
  logic signed [31:0] cur_x_r, cur_y_r;
  logic [15:0]        prev_r;
  logic [16:0]        accum_r;
  logic [CW-1:0]      count_r;
  logic signed [PW-1:0] ptr_r;
  logic               latch_r;

  // per-transaction work registers
  logic signed [15:0]   step_r;
  logic [15:0]          rel_r;
  logic                 flip_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic signed [51:0]   prod_r;
  logic signed [32:0]   dx_r, dy_r;
  logic [33:0]          d2_r;
  logic [15:0]          th_r;
  logic                 sw_r;
  logic [31:0]          rdx_r, rdy_r;
  item_out_t            out_r;

  logic [31:0] store_x [MAX_POINTS];
  logic [31:0] store_y [MAX_POINTS];

  // mean heading and quadrant fold
  logic signed [15:0] hdiff;
  logic [15:0]        mid, mid_q;
  logic               flip;
  always_comb begin
    hdiff = rel_r - prev_r;
    mid   = prev_r + 16'($unsigned(hdiff >>> 1));
    mid_q = mid + 16'h4000;
    flip  = mid_q[15];
  end

  // shared CORDIC step: rotation drives z to zero, vectoring drives y to zero
  logic signed [XW-1:0] sx, sy, cx_n, cy_n;
  logic signed [ZW-1:0] at, cz_n;
  logic                 dir;
  always_comb begin
    sx  = cx_r >>> cmd.iter;
    sy  = cy_r >>> cmd.iter;
    at  = $signed({2'b00, atan_turn(cmd.iter)});
    dir = (cmd.op == OP_ROT_STEP) ? !cz_r[ZW-1] : cy_r[XW-1];
    if (dir) begin
      cx_n = cx_r - sy;
      cy_n = cy_r + sx;
      cz_n = cz_r - at;
    end else begin
      cx_n = cx_r + sy;
      cy_n = cy_r - sx;
      cz_n = cz_r + at;
    end
  end

  // single multiplier, operands picked per command
  logic signed [17:0] step_n;
  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic signed [51:0] prod;
  always_comb begin
    step_n = flip_r ? -18'(step_r) : 18'(step_r);
    case (cmd.op)
      OP_MUL_X: begin
        ma = 34'(cx_r);
        mb = step_n;
      end
      OP_ACC_X: begin
        ma = 34'(cy_r);
        mb = step_n;
      end
      OP_SQ_X: begin
        ma = 34'(dx_r);
        mb = 18'(dx_r);
      end
      OP_SQ_Y: begin
        ma = 34'(dy_r);
        mb = 18'(dy_r);
      end
      OP_SQ_R: begin
        ma = $signed({18'b0, radius_r});
        mb = $signed({2'b0, radius_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = ma * mb;
  end

  logic signed [51:0] rnd_sum, rnd;
  logic [31:0]        inc;
  always_comb begin
    rnd_sum = prod_r + 52'sd536870912;
    rnd     = rnd_sum >>> 30;
    inc     = 32'(rnd);
  end

  // record bookkeeping
  logic [15:0]   abs_step;
  logic [16:0]   accum_n;
  logic [LW-1:0] lim, limit_x, max_x;
  logic          at_spacing, room;
  always_comb begin
    abs_step   = step_r[15] ? (~step_r + 16'd1) : step_r;
    accum_n    = accum_r + {1'b0, abs_step};
    at_spacing = accum_n >= {1'b0, spacing_r};
    limit_x    = LW'(limit_r);
    max_x      = LW'(MAX_POINTS);
    lim        = (limit_x > max_x) ? max_x : limit_x;
    room       = LW'(count_r) < lim;
  end

  // target checks
  logic                 in_range, big, far, near, arrive_sw, zero_vec;
  logic [33:0]          r2;
  logic signed [PW-1:0] ptr_step;
  always_comb begin
    in_range  = (ptr_r >= 0) && (ptr_r < $signed({1'b0, count_r}));
    big       = (dx_r > 33'sd65535) || (dx_r < -33'sd65535) ||
                (dy_r > 33'sd65535) || (dy_r < -33'sd65535);
    r2        = 34'($unsigned(prod_r));
    far       = big || (d2_r > r2);
    near      = !big && (d2_r < r2);
    arrive_sw = near && !latch_r;
    ptr_step  = reverse_r ? (ptr_r - PW'(1)) : (ptr_r + PW'(1));
    zero_vec  = (dx_r == '0) && (dy_r == '0);
  end

  logic [31:0] z_rnd;
  assign z_rnd = cz_r[31:0] + 32'h0000_8000;

  // configuration and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_r      <= 16'd0;
      spacing_r <= 16'd1600;
      radius_r  <= 16'd800;
      reverse_r <= 1'b0;
      limit_r   <= 11'd1024;
      func_r    <= FUNC_RECORD;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      prev_r    <= '0;
      accum_r   <= '0;
      count_r   <= '0;
      ptr_r     <= '0;
      latch_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_HEADING_ZERO:   hz_r      <= cfg_data;
          REG_RECORD_SPACING: spacing_r <= cfg_data;
          REG_ARRIVE_RADIUS:  radius_r  <= cfg_data;
          REG_REPLAY_REVERSE: reverse_r <= cfg_data[0];
          REG_POINT_LIMIT:    limit_r   <= cfg_data[10:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD:  func_r  <= in_data.func;
        OP_ACC_X: cur_x_r <= cur_x_r + inc;
        OP_ACC_Y: begin
          cur_y_r <= cur_y_r + inc;
          prev_r  <= rel_r;
        end
        OP_RECORD: begin
          if (at_spacing) begin
            accum_r <= '0;
            if (room) count_r <= count_r + CW'(1);
          end else begin
            accum_r <= accum_n;
          end
        end
        OP_ARRIVE: begin
          if (far) latch_r <= 1'b0;
          if (arrive_sw) begin
            latch_r <= 1'b1;
            ptr_r   <= ptr_step;
          end
        end
        OP_RESTART: begin
          ptr_r   <= reverse_r ? PW'($signed({1'b0, count_r}) - PW'(1)) : '0;
          latch_r <= 1'b0;
        end
        OP_CLEAR: begin
          cur_x_r <= '0;
          cur_y_r <= '0;
          accum_r <= '0;
          count_r <= '0;
          ptr_r   <= '0;
          latch_r <= 1'b0;
          prev_r  <= rel_r;
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (cmd.op)
      OP_LOAD: begin
        step_r <= in_data.step_dist;
        rel_r  <= in_data.heading - hz_r;
        th_r   <= '0;
        sw_r   <= 1'b0;
      end
      OP_ROT_INIT: begin
        flip_r <= flip;
        cx_r   <= XW'(TRIG_GAIN);
        cy_r   <= '0;
        cz_r   <= ZW'($signed({mid[15] ^ flip, mid[14:0], 16'h0000}));
      end
      OP_ROT_STEP, OP_VEC_STEP: begin
        cx_r <= cx_n;
        cy_r <= cy_n;
        cz_r <= cz_n;
      end
      OP_DIFF: begin
        dx_r <= $signed({rdx_r[31], rdx_r}) - $signed({cur_x_r[31], cur_x_r});
        dy_r <= $signed({rdy_r[31], rdy_r}) - $signed({cur_y_r[31], cur_y_r});
      end
      OP_SQ_Y: d2_r <= 34'($unsigned(prod_r));
      OP_SQ_R: d2_r <= d2_r + 34'($unsigned(prod_r));
      OP_ARRIVE: begin
        if (arrive_sw) sw_r <= 1'b1;
      end
      OP_VEC_INIT: begin
        // fold the left half-plane over so the vector starts in x >= 0
        if (dx_r[32]) begin
          cx_r <= -(XW'(dx_r) <<< 16);
          cy_r <= -(XW'(dy_r) <<< 16);
          cz_r <= $signed({2'b00, 32'h8000_0000});
        end else begin
          cx_r <= XW'(dx_r) <<< 16;
          cy_r <= XW'(dy_r) <<< 16;
          cz_r <= '0;
        end
      end
      OP_BEAR: th_r <= z_rnd[31:16];
      default: ;
    endcase
  end

  // breadcrumb store
  logic wr_en;
  assign wr_en = (cmd.op == OP_RECORD) && at_spacing && room;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_x[count_r[AW-1:0]] <= cur_x_r;
      store_y[count_r[AW-1:0]] <= cur_y_r;
    end
    if (cmd.op == OP_RD) begin
      rdx_r <= store_x[ptr_r[AW-1:0]];
      rdy_r <= store_y[ptr_r[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_r.pos_x            <= cur_x_r;
      out_r.pos_y            <= cur_y_r;
      out_r.target_heading   <= th_r;
      out_r.relative_heading <= rel_r;
      out_r.replay_active    <= in_range;
      out_r.point_switched   <= sw_r;
      out_r.target_index     <= 12'(ptr_r);
      out_r.stored_points    <= 11'(count_r);
    end
  end

  always_comb begin
    stat.func      = func_r;
    stat.in_range  = in_range;
    stat.arrive_sw = arrive_sw;
    stat.zero_vec  = zero_vec;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: rtl/odometry_path_record_replay.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_data   (item_in_t: func, step_dist, heading)
// out      out_valid / out_ready out_data  (item_out_t: position, bearing, status)
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data (cfg_ready is always high)
//
// One transaction at a time. Record and replay ticks spend most of their time in the
// 16-step CORDIC passes (sin/cos of the mean heading, then, for replay, bearing to
// target); restart and clear run none. A result waits in the output register
// while the next transaction is taken; the block stalls at its end only if that
// register is still full. Reset is synchronous, active low; the point store is not
// cleared and needs no sweep.
`default_nettype none

`include "odometry_path_record_replay_defines.svh"

module odometry_path_record_replay import opr_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire item_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output item_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  opr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  opr_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  `OPR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `OPR_ASSERT_NOW(a_idle_bearing_zero, out_valid && !out_data.replay_active,
                  out_data.target_heading == 16'sd0)
  `OPR_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(!in_ready))

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb import opr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  item_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  item_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  odometry_path_record_replay uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int      NPTS = 1024;
  localparam longint  GAIN = 64'sd652032874;
  localparam longint  ATAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  // predictor copy of registers and state
  logic [15:0] hz, spacing, radius;
  logic        reverse;
  logic [10:0] plimit;
  logic [31:0] px, py, acc;
  logic [15:0] prev_h;
  int          cnt, tptr;
  logic        latch;
  logic [31:0] sx [NPTS];
  logic [31:0] sy [NPTS];
  logic signed [15:0] last_bear;

  item_out_t   exp_q [$];
  int          err_cnt, n_items, n_switch, n_stored_max;
  bit          quiet;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

  function automatic void sincos(input logic [15:0] ang, output longint c,
                                 output longint s);
    logic [31:0] ua;
    logic [31:0] t;
    bit          flip;
    longint      z, x, y, nx;
    ua = {ang, 16'h0};
    t = ua + 32'h4000_0000;
    flip = t[31];
    if (flip) ua = ua + 32'h8000_0000;
    z = longint'(signed'(ua));
    x = GAIN;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_TURN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] bearing_to(input longint dx, input longint dy);
    longint      x, y, nx;
    logic [31:0] z, r;
    if (dx == 0 && dy == 0) return 16'h0;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + 32'(ATAN_TURN[i]);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - 32'(ATAN_TURN[i]);
      end
      x = nx;
    end
    r = (z + 32'h8000) >> 16;
    return r[15:0];
  endfunction

  function automatic bit has_target(input int idx);
    return idx >= 0 && idx < cnt && idx < NPTS;
  endfunction

  function automatic void dead_reckon(input longint step, input logic [15:0] rel);
    logic [15:0] d, mid;
    longint      sd, c, s;
    d = rel - prev_h;
    sd = longint'(signed'(d));
    mid = prev_h + 16'((sd + 32768) >> 1) + 16'hC000;
    sincos(mid, c, s);
    px = px + 32'((step * c + (64'sd1 << 29)) >>> 30);
    py = py + 32'((step * s + (64'sd1 << 29)) >>> 30);
    prev_h = rel;
  endfunction

  function automatic item_out_t predict_tick(input item_in_t it);
    item_out_t   r;
    logic [15:0] rel, th;
    longint      step, dx, dy, d2, r2;
    bit          sw, big, far_off, near;
    int          idx, lim;
    rel = it.heading - hz;
    step = longint'(it.step_dist);
    th = 0;
    sw = 0;
    case (it.func)
      FUNC_RECORD: begin
        dead_reckon(step, rel);
        acc = acc + 32'(step < 0 ? -step : step);
        if (acc >= {16'h0, spacing}) begin
          lim = plimit < NPTS ? int'(plimit) : NPTS;
          acc = 0;
          if (cnt < lim) begin
            sx[cnt] = px; sy[cnt] = py; cnt++;
          end
        end
      end
      FUNC_REPLAY: begin
        dead_reckon(step, rel);
        idx = tptr;
        if (has_target(idx)) begin
          dx = longint'(signed'(sx[idx])) - longint'(signed'(px));
          dy = longint'(signed'(sy[idx])) - longint'(signed'(py));
          big = dx >= 65536 || dx <= -65536 || dy >= 65536 || dy <= -65536;
          d2 = big ? 0 : dx * dx + dy * dy;
          r2 = longint'(radius) * longint'(radius);
          far_off = big || d2 > r2;
          near = !big && d2 < r2;
          if (far_off) latch = 0;
          if (near && !latch) begin
            latch = 1;
            idx = idx + (reverse ? -1 : 1);
            tptr = idx;
            sw = 1;
            if (has_target(idx)) begin
              dx = longint'(signed'(sx[idx])) - longint'(signed'(px));
              dy = longint'(signed'(sy[idx])) - longint'(signed'(py));
            end
          end
          if (has_target(idx)) th = bearing_to(dx, dy);
        end
        last_bear = th;
      end
      FUNC_RESTART: begin
        tptr = reverse ? cnt - 1 : 0;
        latch = 0;
      end
      default: begin
        px = 0; py = 0; acc = 0; cnt = 0; tptr = 0; latch = 0;
        prev_h = rel;
      end
    endcase
    r.pos_x = px;
    r.pos_y = py;
    r.target_heading = th;
    r.relative_heading = rel;
    r.replay_active = has_target(tptr);
    r.point_switched = sw;
    r.target_index = 12'(tptr);
    r.stored_points = 11'(cnt);
    n_switch += sw;
    if (cnt > n_stored_max) n_stored_max = cnt;
    return r;
  endfunction

  task automatic send_tick(input logic [1:0] f, input logic [15:0] step,
                           input logic [15:0] hd);
    item_in_t it;
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.func = f;
    it.step_dist = step;
    it.heading = hd;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    exp_q.push_back(predict_tick(it));
    n_items++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEADING_ZERO:   hz = val;
      REG_RECORD_SPACING: spacing = val;
      REG_ARRIVE_RADIUS:  radius = val;
      REG_REPLAY_REVERSE: reverse = val[0];
      REG_POINT_LIMIT:    plimit = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [15:0] z, input logic [15:0] sp,
                         input logic [15:0] rad, input bit rev,
                         input logic [15:0] lim);
    drain_results();
    write_reg(REG_HEADING_ZERO, z);
    write_reg(REG_RECORD_SPACING, sp);
    write_reg(REG_ARRIVE_RADIUS, rad);
    write_reg(REG_REPLAY_REVERSE, {15'h0, rev});
    write_reg(REG_POINT_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic chk(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    item_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        e = exp_q.pop_front();
        chk("pos_x", e.pos_x, out_data.pos_x);
        chk("pos_y", e.pos_y, out_data.pos_y);
        chk("target_heading", e.target_heading, out_data.target_heading);
        chk("relative_heading", e.relative_heading, out_data.relative_heading);
        chk("replay_active", e.replay_active, out_data.replay_active);
        chk("point_switched", e.point_switched, out_data.point_switched);
        chk("target_index", e.target_index, out_data.target_index);
        chk("stored_points", e.stored_points, out_data.stored_points);
      end
    end
    out_ready <= quiet || $urandom_range(99) >= 6;
  end

  task automatic test_directed();
    set_all(16'h0, 16'd1, 16'd800, 1'b0, 16'd1024);
    send_tick(FUNC_CLEAR, 16'h0, 16'h0);
    send_tick(FUNC_RECORD, 16'h7FFF, 16'h0);
    send_tick(FUNC_RECORD, 16'h8000, 16'h8000);
    send_tick(FUNC_RECORD, 16'h0001, 16'hFFFF);
    send_tick(FUNC_RECORD, 16'hFFFF, 16'h4000);
    send_tick(FUNC_RECORD, 16'h0000, 16'hC000);
    send_tick(FUNC_RESTART, 16'hFFFF, 16'hFFFF);
    send_tick(FUNC_REPLAY, 16'h0, 16'h0);
    send_tick(FUNC_REPLAY, 16'h0, 16'h0);
    send_tick(FUNC_REPLAY, 16'h7FFF, 16'h8000);
    send_tick(FUNC_REPLAY, 16'h0, 16'h0);
    // target straight behind: point at -x, stand still at origin after clear
    send_tick(FUNC_CLEAR, 16'h0, 16'h0);
    send_tick(FUNC_RECORD, 16'hF000, 16'h0);
    send_tick(FUNC_RECORD, 16'h1000, 16'h0);
    send_tick(FUNC_RESTART, 16'h0, 16'h0);
    send_tick(FUNC_REPLAY, 16'h0, 16'h0);
    // reverse restart with nothing stored leaves target at -1
    send_tick(FUNC_CLEAR, 16'h5555, 16'hAAAA);
    set_all(16'hFFFF, 16'd1, 16'd1, 1'b1, 16'd2047);
    send_tick(FUNC_RESTART, 16'h0, 16'h0);
    send_tick(FUNC_REPLAY, 16'h1234, 16'hFFFF);
    send_tick(FUNC_RECORD, 16'h0, 16'h0);
  endtask

  // record a wandering path, then replay it while steering at the target
  task automatic run_path(input int n_rec, input int n_rep);
    logic [15:0] hd;
    hd = 16'($urandom);
    send_tick(FUNC_CLEAR, 16'($urandom), hd);
    for (int i = 0; i < n_rec; i++) begin
      hd = hd + 16'($urandom_range(4000)) - 16'd2000;
      if ($urandom_range(99) < 5)
        send_tick(2'($urandom), 16'($urandom), 16'($urandom));
      else
        send_tick(FUNC_RECORD, 16'($urandom_range(1000)) - 16'd100, hd);
    end
    send_tick(FUNC_RESTART, 16'($urandom), 16'($urandom));
    for (int i = 0; i < n_rep; i++) begin
      if ($urandom_range(99) < 5)
        send_tick(2'($urandom), 16'($urandom), 16'($urandom));
      else if ($urandom_range(99) < 8)
        send_tick(FUNC_RESTART, 16'h0, 16'($urandom));
      else
        send_tick(FUNC_REPLAY, 16'($urandom_range(700)),
                  16'(last_bear) + hz + 16'($urandom_range(1200)) - 16'd600);
    end
  endtask

  task automatic test_random(input int budget);
    int stop_at;
    stop_at = n_items + budget;
    while (n_items < stop_at)
      run_path($urandom_range(5, 40), $urandom_range(10, 60));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_HEADING_ZERO;
    cfg_data = '0;
    quiet = 0;
    err_cnt = 0; n_items = 0; n_switch = 0; n_stored_max = 0;
    hz = 0; spacing = 16'd1600; radius = 16'd800; reverse = 0; plimit = 11'd1024;
    px = 0; py = 0; acc = 0; prev_h = 0; cnt = 0; tptr = 0; latch = 0;
    last_bear = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values first, before any register write
    send_tick(FUNC_RECORD, 16'd1700, 16'h0);
    send_tick(FUNC_RESTART, 16'h0, 16'h0);
    send_tick(FUNC_REPLAY, 16'hF800, 16'h0);
    test_directed();

    set_all(16'h0, 16'd1600, 16'd800, 1'b0, 16'd1024);
    test_random(350);
    set_all(16'h4000, 16'd400, 16'd300, 1'b1, 16'd1024);
    test_random(350);
    quiet = 1;
    set_all(16'hFFFF, 16'd1, 16'd65535, 1'b0, 16'd3);
    test_random(250);
    quiet = 0;
    set_all(16'h8000, 16'd65535, 16'd1, 1'b1, 16'd0);
    test_random(150);
    set_all(16'($urandom), 16'd900, 16'd1200, 1'b1, 16'd2047);
    test_random(350);
    set_all(16'($urandom), 16'd1, 16'd500, 1'b0, 16'd1024);
    test_random(400);

    drain_results();
    $display("tb: %0d ticks over reset values and 8 register settings", n_items);
    $display("tb: %0d target switches, up to %0d points", n_switch, n_stored_max);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
